/* rtl/plti_pkg.sv */
// ---------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise linear table interpolator.
// ---------------------------------------------------------------------------
package plti_pkg;

   localparam int MaxPoints  = 16;
   localparam int IdxWidth   = $clog2(MaxPoints);
   localparam int CntWidth   = 5;
   localparam int ValWidth   = 32;
   localparam int StatWidth  = 3;
   localparam int QueueDepth = 2;

   localparam logic [ValWidth-1:0] OneQ16 = 32'sd65536;

   localparam logic [StatWidth-1:0] StatInterp    = 3'd0;
   localparam logic [StatWidth-1:0] StatClampLow  = 3'd1;
   localparam logic [StatWidth-1:0] StatClampHigh = 3'd2;
   localparam logic [StatWidth-1:0] StatEmpty     = 3'd3;
   localparam logic [StatWidth-1:0] StatNoSegment = 3'd4;

   // A query handed from the front end to the arithmetic back end.
   typedef struct packed {
      logic                 direct;    // result is known, no arithmetic needed
      logic [StatWidth-1:0] status;
      logic [ValWidth-1:0]  value;     // direct result, or y0 for interpolation
      logic [ValWidth:0]    dy;        // y1 - y0, signed
      logic [ValWidth:0]    dv;        // v - x0, non-negative
      logic [ValWidth:0]    dx;        // x1 - x0, positive
   } job_type;

   typedef struct packed {
      logic [ValWidth-1:0]  value;
      logic [StatWidth-1:0] status;
   } result_type;

endpackage

/* rtl/plti_front.sv */
// ---------------------------------------------------------------------------
// plti_front
// Holds the breakpoint table, takes load and query beats and, for a query,
// walks the table one entry a cycle to classify it and pick the segment.
// ---------------------------------------------------------------------------
module plti_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_action,
   input  logic [plti_pkg::IdxWidth-1:0] req_index,
   input  logic [plti_pkg::ValWidth-1:0] req_x,
   input  logic [plti_pkg::ValWidth-1:0] req_y,
   input  logic [plti_pkg::ValWidth-1:0] req_query,
   input  logic [plti_pkg::CntWidth-1:0] point_count,
   output logic                      job_valid,
   input  logic                      job_ready,
   output plti_pkg::job_type         job_data
);
   import plti_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_FIRST, S_LAST, S_SCAN, S_SEG, S_PUSH
   } state_type;

   logic [ValWidth-1:0] mem_x [MaxPoints];
   logic [ValWidth-1:0] mem_y [MaxPoints];
   logic [ValWidth-1:0] rd_x_ff, rd_y_ff;
   logic [IdxWidth-1:0] rd_addr;

   state_type           state_ff, state_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic [IdxWidth-1:0] last_ff, last_in;
   logic [ValWidth-1:0] v_ff, v_in;
   logic [ValWidth-1:0] px_ff, px_in, py_ff, py_in;
   job_type             job_ff, job_in;
   logic                load_fire;
   logic [CntWidth-1:0] n_clip;

   assign req_tready = (state_ff == S_IDLE);
   assign load_fire  = req_tvalid && req_tready && !req_action;
   assign n_clip     = (point_count > CntWidth'(MaxPoints)) ?
                       CntWidth'(MaxPoints) : point_count;

   // Memory read address is chosen combinationally, data registered.
   always_comb begin
      rd_addr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         mem_x[req_index] <= req_x;
         mem_y[req_index] <= req_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      v_in     = v_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      job_in   = job_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_action) begin
               v_in         = req_query;
               last_in      = IdxWidth'(n_clip - 1'b1);
               idx_in       = '0;
               job_in       = '0;
               job_in.direct = 1'b1;
               if (n_clip == '0) begin
                  job_in.value  = OneQ16;
                  job_in.status = StatEmpty;
                  state_in      = S_PUSH;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            // rd_x_ff holds entry 0.
            if ($signed(v_ff) <= $signed(rd_x_ff)) begin
               job_in.value  = rd_y_ff;
               job_in.status = StatClampLow;
               state_in      = S_PUSH;
            end else begin
               idx_in   = last_ff;
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if ($signed(v_ff) >= $signed(rd_x_ff)) begin
               job_in.value  = rd_y_ff;
               job_in.status = StatClampHigh;
               state_in      = S_PUSH;
            end else begin
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Latch x[i-1], y[i-1], then advance to entry i.
            px_in    = rd_x_ff;
            py_in    = rd_y_ff;
            idx_in   = idx_ff + 1'b1;
            state_in = S_SEG;
         end
         S_SEG: begin
            if ($signed(v_ff) >= $signed(px_ff) && $signed(v_ff) < $signed(rd_x_ff)) begin
               job_in.direct = 1'b0;
               job_in.status = StatInterp;
               job_in.value  = py_ff;
               job_in.dy = {rd_y_ff[ValWidth-1], rd_y_ff} - {py_ff[ValWidth-1], py_ff};
               job_in.dv = {v_ff[ValWidth-1], v_ff} - {px_ff[ValWidth-1], px_ff};
               job_in.dx = {rd_x_ff[ValWidth-1], rd_x_ff} - {px_ff[ValWidth-1], px_ff};
               state_in  = S_PUSH;
            end else if (idx_ff == last_ff) begin
               job_in.value  = OneQ16;
               job_in.status = StatNoSegment;
               state_in      = S_PUSH;
            end else begin
               px_in  = rd_x_ff;
               py_in  = rd_y_ff;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_PUSH: begin
            if (job_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      last_ff <= last_in;
      v_ff    <= v_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      job_ff  <= job_in;
   end

   assign job_valid = (state_ff == S_PUSH);
   assign job_data  = job_ff;

endmodule

/* rtl/plti_queue.sv */
// ---------------------------------------------------------------------------
// plti_queue
// Short queue of classified queries between the front and back ends.
// ---------------------------------------------------------------------------
module plti_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  plti_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output plti_pkg::job_type out_data
);
   import plti_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);

   job_type             slot_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ff, rd_ff;
   logic [PtrWidth:0]   cnt_ff;
   logic                push, pop;

   assign in_ready  = (cnt_ff != (PtrWidth+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
      end
   end

endmodule

/* rtl/plti_back.sv */
// ---------------------------------------------------------------------------
// plti_back
// Passes a direct result through, or computes y0 + dy*dv/dx: a 32x32 multiply
// split into two 32x16 halves (S_MUL_LO, S_MUL_HI), then a restoring divide
// one quotient bit a cycle, and an output register.
// ---------------------------------------------------------------------------
module plti_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  plti_pkg::job_type     job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plti_pkg::result_type  rsp_data
);
   import plti_pkg::*;

   localparam int ProdWidth = 2 * ValWidth;   // |dy| < 2^32, dv < 2^32
   localparam int StepWidth = $clog2(ProdWidth + 1);
   localparam int HalfWidth = ValWidth / 2;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_LO, S_MUL_HI, S_DIV, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [ValWidth-1:0]   mag_ff, mag_in;
   logic [ValWidth-1:0]   dv_ff, dv_in;
   logic [ValWidth:0]     dx_ff, dx_in;
   logic [ValWidth-1:0]   y0_ff, y0_in;
   logic [ProdWidth-1:0]  prod_ff, prod_in;
   logic [ValWidth:0]     rem_ff, rem_in;
   logic [ProdWidth-1:0]  quo_ff, quo_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   result_type            res_ff, res_in;
   logic [ValWidth:0]     dy_abs;
   logic [ValWidth+1:0]   trial;
   logic [HalfWidth-1:0]  mul_half;
   logic [ValWidth+HalfWidth-1:0] part_prod;

   assign dy_abs = job_data.dy[ValWidth] ? (~job_data.dy + 1'b1) : job_data.dy;
   assign trial  = {rem_ff, prod_ff[ProdWidth-1]} - {1'b0, dx_ff};

   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = res_ff;

   // One 32x16 multiplier serves both halves of dv.
   always_comb begin
      mul_half  = (state_ff == S_MUL_LO) ? dv_ff[HalfWidth-1:0]
                                         : dv_ff[ValWidth-1:HalfWidth];
      part_prod = mag_ff * mul_half;
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      dv_in    = dv_ff;
      dx_in    = dx_ff;
      y0_in    = y0_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               neg_in = job_data.dy[ValWidth];
               mag_in = dy_abs[ValWidth-1:0];
               dv_in  = job_data.dv[ValWidth-1:0];
               dx_in  = job_data.dx;
               y0_in  = job_data.value;
               if (job_data.direct) begin
                  res_in.value  = job_data.value;
                  res_in.status = job_data.status;
                  state_in      = S_OUT;
               end else begin
                  res_in.status = StatInterp;
                  state_in      = S_MUL_LO;
               end
            end
         end
         S_MUL_LO: begin
            // Low half of dv against the full magnitude.
            prod_in  = {{HalfWidth{1'b0}}, part_prod};
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = prod_ff + {part_prod, {HalfWidth{1'b0}}};
            rem_in   = '0;
            quo_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!trial[ValWidth+1]) begin
               rem_in = trial[ValWidth:0];
               quo_in = {quo_ff[ProdWidth-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[ValWidth-1:0], prod_ff[ProdWidth-1]};
               quo_in = {quo_ff[ProdWidth-2:0], 1'b0};
            end
            prod_in = {prod_ff[ProdWidth-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(ProdWidth - 1)) begin
               state_in     = S_OUT;
               res_in.value = neg_ff ? (y0_ff - quo_in[ValWidth-1:0])
                                     : (y0_ff + quo_in[ValWidth-1:0]);
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      dv_ff   <= dv_in;
      dx_ff   <= dx_in;
      y0_ff   <= y0_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

endmodule

/* rtl/piecewise_linear_table_interp.sv */
// ---------------------------------------------------------------------------
// piecewise_linear_table_interp
// Piecewise linear interpolation over a 16 entry breakpoint table, Q16.16.
// ---------------------------------------------------------------------------
// A req beat with action 0 writes breakpoint entry_index (x, y) and gives no
// rsp beat. A req beat with action 1 is a query and gives one rsp beat with
// result_value and status. point_count is written on the csr channel only
// while the block is idle, a rule for the user that the block does not
// enforce; values above 16 act as 16. The front end walks the table one
// entry a cycle: a query is first checked for clamping low against entry 0
// (S_FIRST), then for clamping high against the last entry (S_LAST), and
// only then is the table scanned segment by segment, up to point_count - 1;
// an empty table skips all of these. The back end multiplies in two halves,
// then divides one quotient bit a cycle for a 64-bit quotient. A load is
// written straight into the table.
// A two entry queue lets the front end classify the next query while the
// back end divides. When rsp_tready is low the result holds in the back
// end's output register and back pressure reaches req_tready via the queue.
// Reset clears control state and point_count; table contents are kept.
// ---------------------------------------------------------------------------
module piecewise_linear_table_interp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[0], entry_index[4:1], entry_x[36:5], entry_y[68:37],
   // query_value[100:69], zero fill to 104 bits
   input  logic [103:0] req_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [plti_pkg::CntWidth-1:0] csr_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[31:0], status[34:32], zero fill to 40 bits
   output logic [39:0] rsp_tdata
);
   import plti_pkg::*;

   logic [CntWidth-1:0] count_ff;
   logic                fj_valid, fj_ready, bj_valid, bj_ready;
   job_type             fj_data, bj_data;
   result_type          res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   plti_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_action  (req_tdata[0]),
      .req_index   (req_tdata[4:1]),
      .req_x       (req_tdata[36:5]),
      .req_y       (req_tdata[68:37]),
      .req_query   (req_tdata[100:69]),
      .point_count (count_ff),
      .job_valid   (fj_valid),
      .job_ready   (fj_ready),
      .job_data    (fj_data)
   );

   plti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fj_valid),
      .in_ready  (fj_ready),
      .in_data   (fj_data),
      .out_valid (bj_valid),
      .out_ready (bj_ready),
      .out_data  (bj_data)
   );

   plti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bj_valid),
      .job_ready (bj_ready),
      .job_data  (bj_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (res)
   );

   assign rsp_tdata = {5'd0, res.status, res.value};

endmodule

/* sim/tb_piecewise_linear_table_interp.sv */
// ---------------------------------------------------------------------------
// tb_piecewise_linear_table_interp
// Self-checking testbench for the piecewise linear table interpolator.
// ---------------------------------------------------------------------------
// Breakpoint loads and queries are streamed into the block with random gaps.
// Every query is predicted by a Q16.16 interpolator kept in a scoreboard
// class, and each result beat is checked in order against it. point_count
// is changed between phases while the block is idle. Phases cover sorted,
// unordered and degenerate tables, a long result hold-off and a full drain.
// ---------------------------------------------------------------------------
module tb_piecewise_linear_table_interp;
   timeunit 1ns;
   timeprecision 1ps;
   import plti_pkg::*;

   localparam logic ActLoad  = 1'b0;
   localparam logic ActQuery = 1'b1;
   localparam int   SettleCycles = 150;
   localparam int   HoldCycles   = 600;
   localparam int   CycleLimit   = 1000000;

   typedef struct {
      logic [ValWidth-1:0]  value;
      logic [StatWidth-1:0] status;
   } answer_type;

   class interp_scoreboard;
      longint             tab_x[MaxPoints];
      longint             tab_y[MaxPoints];
      int unsigned        count;
      answer_type         pending_answers[$];
      int                 mismatches;

      function new();
         count = 0;
         mismatches = 0;
         foreach (tab_x[i]) begin
            tab_x[i] = 0;
            tab_y[i] = 0;
         end
      endfunction

      function void note_request(logic act, logic [IdxWidth-1:0] idx,
                                 logic signed [31:0] ex, logic signed [31:0] ey,
                                 logic signed [31:0] qv);
         answer_type ans;
         int         n;
         longint     v, res, x0, x1, y0, dy;
         bit [127:0] mag, dv, dx, quot;
         if (act == ActLoad) begin
            tab_x[idx] = ex;
            tab_y[idx] = ey;
            return;
         end
         n = (count > MaxPoints) ? MaxPoints : count;
         v = qv;
         if (n == 0) begin
            res = 65536;
            ans.status = StatEmpty;
         end else if (v <= tab_x[0]) begin
            res = tab_y[0];
            ans.status = StatClampLow;
         end else if (v >= tab_x[n-1]) begin
            res = tab_y[n-1];
            ans.status = StatClampHigh;
         end else begin
            res = 65536;
            ans.status = StatNoSegment;
            for (int i = 1; i < n; i++) begin
               x0 = tab_x[i-1];
               x1 = tab_x[i];
               if (v >= x0 && v < x1) begin
                  y0 = tab_y[i-1];
                  dy = tab_y[i] - y0;
                  mag = (dy < 0) ? -dy : dy;
                  dv = v - x0;
                  dx = x1 - x0;
                  quot = (mag * dv) / dx;
                  res = (dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot);
                  ans.status = StatInterp;
                  break;
               end
            end
         end
         ans.value = res[31:0];
         pending_answers.push_back(ans);
      endfunction

      function void check_result(logic [ValWidth-1:0] value,
                                 logic [StatWidth-1:0] status);
         answer_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: value %h status %0d", value, status);
            return;
         end
         want = pending_answers.pop_front();
         if (want.value !== value || want.status !== status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Result mismatch: expected value %h status %0d, got %h status %0d",
                        want.value, want.status, value, status);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [103:0]        req_tdata = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CntWidth-1:0] csr_data = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;

   interp_scoreboard sb = new();
   bit          quiet_mode;
   bit          hold_off_req;
   int unsigned cycles = 0;

   piecewise_linear_table_interp uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off once requested.
   initial begin
      int hold_cnt;
      bit hold_taken;
      hold_cnt = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            rsp_tready = 1'b0;
            hold_cnt++;
            if (hold_cnt == HoldCycles)
               hold_taken = 1'b1;
         end else begin
            rsp_tready = quiet_mode || ($urandom_range(99) >= 9);
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[31:0], rsp_tdata[34:32]);
      end
   end

   // All request tasks start and end at a falling edge.
   task automatic send_beat(logic act, logic [IdxWidth-1:0] idx,
                            logic [31:0] ex, logic [31:0] ey, logic [31:0] qv);
      while (!quiet_mode && $urandom_range(99) < 9)
         @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {3'b000, qv, ey, ex, idx, act};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, idx, ex, ey, qv);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending_answers.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_count(logic [CntWidth-1:0] n);
      wait_drained();
      repeat (SettleCycles) @(negedge clock);
      csr_valid = 1'b1;
      csr_data = n;
      do @(posedge clock); while (!csr_ready);
      sb.count = n;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Loads a full table with either a wide or a narrow x span, sorted if asked.
   task automatic load_table(bit sorted);
      int xs[$];
      int span;
      span = $urandom_range(1) ? 0 : $urandom_range(4000, 1);
      for (int i = 0; i < MaxPoints; i++)
         xs.push_back(span == 0 ? int'($urandom) : int'($urandom_range(span)) - span / 2);
      if (sorted)
         xs.sort();
      for (int i = 0; i < MaxPoints; i++)
         send_beat(ActLoad, IdxWidth'(i), xs[i], $urandom, $urandom);
   endtask

   function automatic logic [31:0] pick_query();
      int k;
      k = $urandom_range(MaxPoints - 1);
      case ($urandom_range(3))
         0: return $urandom;
         1: return sb.tab_x[k][31:0];
         2: return sb.tab_x[k][31:0] + $urandom_range(64) - 32;
         default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   initial begin
      logic [CntWidth-1:0] counts[8];
      longint              dx;
      quiet_mode = 1'b0;
      hold_off_req = 1'b0;
      counts = '{16, 16, 31, 5, 2, 1, 0, 17};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table, then a table spanning the whole range with extreme slopes.
      send_beat(ActQuery, 0, 0, 0, 32'h8000_0000);
      send_beat(ActQuery, 0, 0, 0, 32'h7fff_ffff);
      send_beat(ActQuery, 0, 0, 0, 32'h0000_0000);
      for (int i = 0; i < MaxPoints; i++) begin
         dx = -64'sd2147483648 + (longint'(i) * 64'sd4294967295) / 15;
         send_beat(ActLoad, IdxWidth'(i), dx[31:0],
                   (i % 2) ? 32'h7fff_ffff : 32'h8000_0000, 0);
      end
      write_count(CntWidth'(16));
      send_beat(ActQuery, 0, 0, 0, 32'h8000_0000);
      send_beat(ActQuery, 0, 0, 0, 32'h8000_0001);
      send_beat(ActQuery, 0, 0, 0, 32'h0000_0000);
      send_beat(ActQuery, 0, 0, 0, 32'h7fff_fffe);
      send_beat(ActQuery, 0, 0, 0, 32'h7fff_ffff);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         repeat (SettleCycles) @(negedge clock);
         load_table(p != 5);
         write_count(p == 7 ? CntWidth'($urandom_range(31)) : counts[p]);
         quiet_mode = (p == 1);
         for (int k = 0; k < 100; k++) begin
            if (p == 2 && k == 20)
               hold_off_req = 1'b1;
            if (p == 3 && k == 50)
               wait_drained();
            if ($urandom_range(99) < 8)
               send_beat(ActLoad, IdxWidth'($urandom), $urandom, $urandom, $urandom);
            else
               send_beat(ActQuery, IdxWidth'($urandom), $urandom, $urandom,
                         pick_query());
         end
      end
      quiet_mode = 1'b0;

      wait_drained();
      repeat (SettleCycles) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
